// ===== rtl/sparse_diagonal_shift_add_top_defines.svh =====
// Assertion macros for the checker file of the diagonal shift block.
`ifndef SPARSE_DIAGONAL_SHIFT_ADD_TOP_DEFINES_SVH
`define SPARSE_DIAGONAL_SHIFT_ADD_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SDSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdsa: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SDSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdsa: next-cycle check failed");

`endif

// ===== rtl/sdsa_pkg.sv =====
// Shared types, widths and constants of the diagonal shift block.
package sdsa_pkg;

  localparam int IDX_W       = 16;
  localparam int VAL_W       = 64;
  localparam int DIM_W       = 17;
  localparam int PTR_W       = 21;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 104;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QFILL_W     = 3;

  localparam logic [DIM_W-1:0] DIM_MAX = 17'd65536;
  localparam logic [PTR_W-1:0] NNZ_MAX = 21'd1048576;

  localparam logic [VAL_W-1:0] VAL_POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_NEG_MAX = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_SHIFT_VALUE = 2'd0,
    REG_INNER_SIZE  = 2'd1,
    REG_OUTER_SIZE  = 2'd2
  } reg_index_t;

  typedef enum logic {
    OP_ENTRY   = 1'b0,
    OP_COL_END = 1'b1
  } op_t;

  typedef enum logic {
    KIND_ENTRY   = 1'b0,
    KIND_POINTER = 1'b1
  } kind_t;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  out_index;
    logic [VAL_W-1:0]  out_value;
    logic [PTR_W-1:0]  column_pointer;
    logic              overflow;
    logic              matrix_done;
    logic              last;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

// ===== rtl/sdsa_core.sv =====
// Input register, configuration registers, column state and result forming.
module sdsa_core
  import sdsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [VAL_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [IDX_W-1:0] in_index,
  input  logic [VAL_W-1:0] in_value,
  input  logic             room,
  output push_t            push
);

  logic [VAL_W-1:0] shift_value;
  logic [DIM_W-1:0] inner_size;
  logic [DIM_W-1:0] outer_size;

  logic             item_valid;
  logic             item_op;
  logic [IDX_W-1:0] item_index;
  logic [VAL_W-1:0] item_value;

  logic [IDX_W-1:0] col, col_next;
  logic             diag, diag_next;
  logic [PTR_W-1:0] cnt, cnt_next;

  logic             advance;
  logic             want_diag;
  logic             hit;
  logic             ins;
  logic [VAL_W-1:0] sum;
  logic             sat;
  logic [VAL_W-1:0] sat_value;
  logic             ov1, ov2;
  logic [PTR_W-1:0] cnt1, cnt2;
  logic [DIM_W-1:0] cols;
  logic [DIM_W-1:0] col_plus;
  logic             done;

  function automatic result_t make_entry(input logic [IDX_W-1:0] idx,
                                         input logic [VAL_W-1:0] val,
                                         input logic ovf, input logic lst);
    result_t r;
    r.kind           = KIND_ENTRY;
    r.out_index      = idx;
    r.out_value      = val;
    r.column_pointer = '0;
    r.overflow       = ovf;
    r.matrix_done    = 1'b0;
    r.last           = lst;
    return r;
  endfunction

  function automatic result_t make_ptr(input logic [PTR_W-1:0] c,
                                       input logic fin, input logic lst);
    result_t r;
    r.kind           = KIND_POINTER;
    r.out_index      = '0;
    r.out_value      = '0;
    r.column_pointer = c;
    r.overflow       = (c == NNZ_MAX);
    r.matrix_done    = fin;
    r.last           = lst;
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_value <= '0;
      inner_size  <= 17'd1;
      outer_size  <= 17'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SHIFT_VALUE: shift_value <= cfg_data;
        REG_INNER_SIZE:  inner_size  <= cfg_data[DIM_W-1:0];
        REG_OUTER_SIZE:  outer_size  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = item_valid && room;
  assign in_ready = !item_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_op    <= in_op;
      item_index <= in_index;
      item_value <= in_value;
    end
  end

  assign want_diag = ({1'b0, col} < inner_size) && !diag;
  assign hit = want_diag && (item_op == OP_ENTRY) && (item_index == col);
  assign ins = want_diag && (item_op == OP_ENTRY) && (item_index > col);

  assign sum = item_value + shift_value;
  assign sat = (item_value[VAL_W-1] == shift_value[VAL_W-1]) &&
               (sum[VAL_W-1] != item_value[VAL_W-1]);
  assign sat_value = sat ? (item_value[VAL_W-1] ? VAL_NEG_MAX : VAL_POS_MAX) : sum;

  assign ov1  = (cnt == NNZ_MAX);
  assign cnt1 = ov1 ? cnt : cnt + 21'd1;
  assign ov2  = (cnt1 == NNZ_MAX);
  assign cnt2 = ov2 ? cnt1 : cnt1 + 21'd1;

  assign cols     = (outer_size == '0) ? 17'd1 :
                    ((outer_size > DIM_MAX) ? DIM_MAX : outer_size);
  assign col_plus = {1'b0, col} + 17'd1;
  assign done     = (col_plus >= cols);

  always_comb begin
    push.v0  = advance;
    push.v1  = 1'b0;
    push.r0  = make_ptr(cnt, done, 1'b1);
    push.r1  = make_ptr(cnt1, done, 1'b1);
    col_next  = col;
    diag_next = diag;
    cnt_next  = cnt;
    priority if (item_op == OP_ENTRY) begin
      if (hit) begin
        push.r0   = make_entry(item_index, sat_value, sat | ov1, 1'b1);
        cnt_next  = cnt1;
        diag_next = 1'b1;
      end else if (ins) begin
        push.v1   = advance;
        push.r0   = make_entry(col, shift_value, ov1, 1'b0);
        push.r1   = make_entry(item_index, item_value, ov2, 1'b1);
        cnt_next  = cnt2;
        diag_next = 1'b1;
      end else begin
        push.r0  = make_entry(item_index, item_value, ov1, 1'b1);
        cnt_next = cnt1;
      end
    end else begin
      if (want_diag) begin
        push.v1  = advance;
        push.r0  = make_entry(col, shift_value, ov1, 1'b0);
        cnt_next = cnt1;
      end
      diag_next = 1'b0;
      if (done) begin
        col_next = '0;
        cnt_next = '0;
      end else begin
        col_next = col_plus[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      diag <= 1'b0;
      cnt  <= '0;
    end else if (advance) begin
      col  <= col_next;
      diag <= diag_next;
      cnt  <= cnt_next;
    end
  end

endmodule

// ===== rtl/sdsa_outq.sv =====
// Four-entry result queue taking up to two results a cycle and giving one.
module sdsa_outq
  import sdsa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t q [QUEUE_DEPTH];

  logic [QPTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [QPTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [QFILL_W-1:0] fill, fill_next;
  logic [QPTR_W-1:0]  wr_ptr_1;
  logic               pop;
  logic [QFILL_W-1:0] n_push;

  assign room      = (fill <= 3'd2);
  assign out_valid = (fill != '0);
  assign out_res   = q[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_1  = wr_ptr + 2'd1;

  assign n_push      = {2'b00, push.v0} + {2'b00, push.v1};
  assign fill_next   = fill + n_push - {2'b00, pop};
  assign wr_ptr_next = wr_ptr + n_push[QPTR_W-1:0];
  assign rd_ptr_next = rd_ptr + {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push.v0) begin
      q[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      q[wr_ptr_1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

endmodule

// ===== rtl/sparse_diagonal_shift_add_top.sv =====
// Top level of the streamed A + c*I block for compressed sparse matrices.
//
// Input stream s_axis: one transfer per stored nonzero (tuser = 0) or per
// column end marker (tuser = 1). Output stream m_axis: entries (tuser = 0)
// and column pointers (tuser = 1); tlast marks the final result of each
// input transfer. Registers (shift value, inner size, outer size) are
// written through cfg_*; the user must write them only while the stream
// is idle, not enforced by the block. cfg_ready is always high. A result
// passes the input register, then the result queue. One input per cycle
// while each gives one result; a transfer that inserts a diagonal entry
// gives two results, and the single output port sets the pace at one
// result per cycle, with the four-entry result queue absorbing the burst.
// Reset clears the column, the count, the queue and the registers (shift
// 0, sizes 1). If the receiver stalls, the queue fills and s_axis_tready
// drops; results are held unchanged until taken, none are lost.
module sparse_diagonal_shift_add_top
  import sdsa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // inner_index, entry_value
  input  logic                   s_axis_tuser,   // op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_index, out_value, column_pointer, overflow, matrix_done, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,   // kind
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [VAL_W-1:0]       cfg_data
);

  push_t   push;
  logic    room;
  result_t out_res;

  sdsa_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_index  (s_axis_tdata[15:0]),
    .in_value  (s_axis_tdata[79:16]),
    .room      (room),
    .push      (push)
  );

  sdsa_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.matrix_done, out_res.overflow,
                         out_res.column_pointer, out_res.out_value, out_res.out_index};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

// ===== rtl/sdsa_checker.sv =====
// Port checker for the diagonal shift block, bound to its top level.
`include "sparse_diagonal_shift_add_top_defines.svh"

module sdsa_checker
  import sdsa_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  logic stalled;
  logic ptr_beat;
  logic entry_beat;

  assign stalled    = m_axis_tvalid && !m_axis_tready;
  assign ptr_beat   = m_axis_tvalid && (m_axis_tuser == KIND_POINTER);
  assign entry_beat = m_axis_tvalid && (m_axis_tuser == KIND_ENTRY);

  `SDSA_ASSERT_NEXT(a_hold_valid, stalled, m_axis_tvalid)
  `SDSA_ASSERT_NEXT(a_hold_data, stalled, $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
  `SDSA_ASSERT_NOW(a_ptr_clean, ptr_beat, (m_axis_tdata[79:0] == '0) && m_axis_tlast)
  `SDSA_ASSERT_NOW(a_entry_clean, entry_beat, (m_axis_tdata[100:80] == '0) && !m_axis_tdata[102])

endmodule

bind sparse_diagonal_shift_add_top sdsa_checker u_sdsa_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sparse_diagonal_shift_add_top_test.sv =====
// Self-checking testbench for the streamed A + c*I block on compressed sparse matrices.
module sparse_diagonal_shift_add_top_test;
  import sdsa_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } stream_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [VAL_W-1:0]       cfg_data = '0;

  sparse_diagonal_shift_add_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus state
  stream_item_t stream_items[$];
  stream_item_t next_item;
  int           items_queued = 0;
  int           items_taken = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  bit           src_gaps_on = 1'b1;
  bit           sink_stalls_on = 1'b1;
  int           gen_col = 0;
  int           gen_outer = 1;

  // Predictor state
  logic [VAL_W-1:0] shift_value = '0;
  logic [DIM_W-1:0] inner_size = 17'd1;
  logic [DIM_W-1:0] outer_size = 17'd1;
  logic [IDX_W-1:0] cur_col = '0;
  logic             diag_done = 1'b0;
  logic [PTR_W-1:0] nnz_count = '0;
  result_t          predicted_beats[$];
  result_t          got_beat;
  result_t          want_beat;
  int               mismatch_count = 0;
  int               cycle_count = 0;

  function automatic logic [VAL_W:0] sat_sum(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] s;
    s = a + b;
    if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1])
      return {1'b1, a[VAL_W-1] ? VAL_NEG_MAX : VAL_POS_MAX};
    return {1'b0, s};
  endfunction

  function automatic result_t make_entry(input logic [IDX_W-1:0] idx,
                                         input logic [VAL_W:0] sum);
    result_t r;
    logic    cov;
    cov = 1'b0;
    if (nnz_count >= NNZ_MAX) begin
      nnz_count = NNZ_MAX;
      cov = 1'b1;
    end else begin
      nnz_count = nnz_count + 1'b1;
    end
    r = '0;
    r.kind = KIND_ENTRY;
    r.out_index = idx;
    r.out_value = sum[VAL_W-1:0];
    r.overflow = sum[VAL_W] | cov;
    return r;
  endfunction

  function automatic void shift_step(input logic op, input logic [IDX_W-1:0] idx,
                                     input logic [VAL_W-1:0] val);
    result_t          res[2];
    int               n;
    logic             want_diag;
    logic [DIM_W-1:0] cols;
    logic             done;
    n = 0;
    want_diag = ({1'b0, cur_col} < inner_size) && !diag_done;
    if (op == OP_ENTRY) begin
      if (want_diag && idx == cur_col) begin
        res[0] = make_entry(idx, sat_sum(val, shift_value));
        diag_done = 1'b1;
        n = 1;
      end else if (want_diag && idx > cur_col) begin
        res[0] = make_entry(cur_col, sat_sum('0, shift_value));
        diag_done = 1'b1;
        res[1] = make_entry(idx, sat_sum(val, '0));
        n = 2;
      end else begin
        res[0] = make_entry(idx, sat_sum(val, '0));
        n = 1;
      end
    end else begin
      cols = outer_size;
      if (cols == '0)
        cols = 17'd1;
      if (cols > DIM_MAX)
        cols = DIM_MAX;
      if (want_diag) begin
        res[0] = make_entry(cur_col, sat_sum('0, shift_value));
        n = 1;
      end
      done = ({1'b0, cur_col} + 17'd1) >= cols;
      res[n] = '0;
      res[n].kind = KIND_POINTER;
      res[n].column_pointer = nnz_count;
      res[n].overflow = nnz_count >= NNZ_MAX;
      res[n].matrix_done = done;
      n++;
      diag_done = 1'b0;
      if (done) begin
        cur_col = '0;
        nnz_count = '0;
      end else begin
        cur_col = cur_col + 1'b1;
      end
    end
    res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++)
      predicted_beats.push_back(res[i]);
  endfunction

  function automatic string beat_text(input result_t r);
    return $sformatf("kind=%0d idx=%0d val=%h ptr=%0d ovf=%0d done=%0d last=%0d",
                     r.kind, r.out_index, r.out_value, r.column_pointer,
                     r.overflow, r.matrix_done, r.last);
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch: %s", msg);
  endfunction

  function automatic int draw_gap(input bit enabled);
    int r;
    if (!enabled)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      return VAL_POS_MAX;
    if (r < 30)
      return VAL_NEG_MAX;
    if (r < 40)
      return {{56{r[0]}}, 8'($urandom)};
    return {$urandom, $urandom};
  endfunction

  // Source: hold the item until transferred, then draw a gap
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stream_items.size() > 0) begin
        next_item = stream_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {next_item.value, next_item.index};
        s_axis_tuser <= next_item.op;
        gap_left <= draw_gap(src_gaps_on);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left <= draw_gap(1'b1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Predict on input transfers, check output transfers
  always @(posedge clk) begin
    if (rst) begin
      shift_value = '0;
      inner_size = 17'd1;
      outer_size = 17'd1;
      cur_col = '0;
      diag_done = 1'b0;
      nnz_count = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHIFT_VALUE: shift_value = cfg_data;
          REG_INNER_SIZE:  inner_size = cfg_data[DIM_W-1:0];
          REG_OUTER_SIZE:  outer_size = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        shift_step(s_axis_tuser, s_axis_tdata[IDX_W-1:0], s_axis_tdata[IDX_W+VAL_W-1:IDX_W]);
        items_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_beat = '0;
        got_beat.kind = m_axis_tuser;
        got_beat.out_index = m_axis_tdata[IDX_W-1:0];
        got_beat.out_value = m_axis_tdata[IDX_W+VAL_W-1:IDX_W];
        got_beat.column_pointer = m_axis_tdata[IDX_W+VAL_W+PTR_W-1:IDX_W+VAL_W];
        got_beat.overflow = m_axis_tdata[IDX_W+VAL_W+PTR_W];
        got_beat.matrix_done = m_axis_tdata[IDX_W+VAL_W+PTR_W+1];
        got_beat.last = m_axis_tlast;
        if (predicted_beats.size() == 0) begin
          note_failure({"unexpected result ", beat_text(got_beat)});
        end else begin
          want_beat = predicted_beats.pop_front();
          if (got_beat.kind !== want_beat.kind
              || got_beat.out_index !== want_beat.out_index
              || got_beat.out_value !== want_beat.out_value
              || got_beat.column_pointer !== want_beat.column_pointer
              || got_beat.overflow !== want_beat.overflow
              || got_beat.matrix_done !== want_beat.matrix_done
              || got_beat.last !== want_beat.last)
            note_failure({"expected ", beat_text(want_beat), " got ", beat_text(got_beat)});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sparse_diagonal_shift_add_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [VAL_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_OUTER_SIZE)
      gen_outer = (data[DIM_W-1:0] == 0) ? 1 : (data[DIM_W-1:0] > DIM_MAX) ? 65536
                  : int'(data[DIM_W-1:0]);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (items_taken != items_queued || predicted_beats.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_item(input op_t op, input int idx, input logic [VAL_W-1:0] val);
    stream_item_t it;
    it.op = op;
    it.index = idx[IDX_W-1:0];
    it.value = val;
    stream_items.push_back(it);
    items_queued++;
    if (op == OP_COL_END)
      gen_col = (gen_col + 1 >= gen_outer) ? 0 : gen_col + 1;
  endtask

  // Sorted entries around the diagonal, then the end marker
  task automatic queue_column();
    int lo;
    int hi;
    bit with_diag;
    lo = (gen_col > 3) ? gen_col - 3 : 0;
    hi = (gen_col + 4 > 65535) ? 65535 : gen_col + 4;
    with_diag = $urandom_range(0, 1);
    for (int i = lo; i <= hi; i++)
      if ((i == gen_col) ? with_diag : ($urandom_range(0, 99) < 35))
        push_item(OP_ENTRY, i, rand_value());
    if (hi < 65535 && $urandom_range(0, 9) == 0)
      push_item(OP_ENTRY, $urandom_range(hi + 1, 65535), rand_value());
    push_item(OP_COL_END, 0, {$urandom, $urandom});
  endtask

  task automatic queue_noise();
    case ($urandom_range(0, 2))
      0: push_item(OP_ENTRY, $urandom_range(0, 65535), rand_value());
      1: begin
        push_item(OP_ENTRY, gen_col, rand_value());
        push_item(OP_ENTRY, gen_col, rand_value());
        push_item(OP_ENTRY, $urandom_range(0, gen_col), rand_value());
      end
      default: push_item(OP_COL_END, $urandom_range(0, 65535), rand_value());
    endcase
  endtask

  task automatic queue_random(input int count);
    int target;
    target = items_queued + count;
    while (items_queued < target)
      if ($urandom_range(0, 99) < 85)
        queue_column();
      else
        queue_noise();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: saturation both ways, insertion before a larger index,
    // insertion at column end, out-of-order and duplicate diagonal entries
    write_reg(REG_SHIFT_VALUE, VAL_POS_MAX);
    write_reg(REG_INNER_SIZE, 64'd4);
    write_reg(REG_OUTER_SIZE, 64'd3);
    push_item(OP_ENTRY, 0, VAL_POS_MAX);
    push_item(OP_ENTRY, 2, 64'h0000_0001_8000_0000);
    push_item(OP_COL_END, 0, '0);
    push_item(OP_ENTRY, 3, 64'hFFFF_FFFF_0000_0000);
    push_item(OP_ENTRY, 0, 64'h1);
    push_item(OP_ENTRY, 1, 64'h2);
    push_item(OP_COL_END, 0, '1);
    push_item(OP_COL_END, 65535, '0);
    wait_idle();
    write_reg(REG_SHIFT_VALUE, VAL_NEG_MAX);
    push_item(OP_ENTRY, 0, VAL_NEG_MAX);
    push_item(OP_ENTRY, 65535, '1);
    push_item(OP_COL_END, 0, '0);
    push_item(OP_ENTRY, 0, VAL_POS_MAX);
    push_item(OP_COL_END, 0, '0);
    push_item(OP_ENTRY, 2, 64'h1);
    push_item(OP_COL_END, 0, '0);
    wait_idle();

    write_reg(REG_SHIFT_VALUE, {$urandom, $urandom});
    write_reg(REG_INNER_SIZE, 64'd6);
    write_reg(REG_OUTER_SIZE, 64'd5);
    queue_random(150);
    wait_idle();

    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    write_reg(REG_SHIFT_VALUE, VAL_POS_MAX);
    write_reg(REG_INNER_SIZE, 64'd65536);
    write_reg(REG_OUTER_SIZE, 64'd65536);
    queue_random(100);
    wait_idle();

    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    write_reg(REG_SHIFT_VALUE, VAL_NEG_MAX);
    write_reg(REG_INNER_SIZE, 64'd1);
    write_reg(REG_OUTER_SIZE, 64'd4);
    queue_random(100);
    wait_idle();

    src_gaps_on = 1'b0;
    write_reg(REG_SHIFT_VALUE, {$urandom, $urandom});
    write_reg(REG_INNER_SIZE, 64'd0);
    write_reg(REG_OUTER_SIZE, 64'd0);
    queue_random(80);
    wait_idle();

    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b0;
    write_reg(REG_SHIFT_VALUE, {$urandom, $urandom});
    write_reg(REG_INNER_SIZE, 64'd3);
    write_reg(REG_OUTER_SIZE, {$urandom, $urandom} | 64'h1FFFF);
    queue_random(100);
    wait_idle();

    // Hold the source mid-phase until every result has drained
    sink_stalls_on = 1'b1;
    write_reg(REG_SHIFT_VALUE, '0);
    write_reg(REG_INNER_SIZE, 64'h1FFFF);
    write_reg(REG_OUTER_SIZE, 64'd8);
    queue_random(60);
    wait_idle();
    queue_random(60);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && predicted_beats.size() == 0)
      $display("** sparse_diagonal_shift_add_top: PASSED **");
    else
      $display("** sparse_diagonal_shift_add_top: FAILED **");
    $finish;
  end

endmodule
